// ===== rtl/pef_pkg.sv =====
// Shared constants and types for the even-odd polygon fill block.
// Used by the controller, the datapath and the top level.
`default_nettype none
package pef_pkg;
   localparam int MaxVerticesDefault = 64;
   localparam int CoordBitsDefault   = 13;
   localparam int LabelBitsDefault   = 32;
   localparam int DimBits            = 13;
   localparam int CsrIndexBits       = 3;

   localparam logic [1:0] CMD_CLEAR  = 2'd0;
   localparam logic [1:0] CMD_ADD    = 2'd1;
   localparam logic [1:0] CMD_TEST   = 2'd2;
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   localparam logic [CsrIndexBits-1:0] CSR_IMAGE_WIDTH  = 3'd0;
   localparam logic [CsrIndexBits-1:0] CSR_IMAGE_HEIGHT = 3'd1;
   localparam logic [CsrIndexBits-1:0] CSR_FILL_LABEL   = 3'd2;
   localparam logic [CsrIndexBits-1:0] CSR_MASK_LABEL   = 3'd3;
   localparam logic [CsrIndexBits-1:0] CSR_MASK_ENABLE  = 3'd4;

   typedef struct packed {
      logic latch;     // capture the accepted word
      logic exec;      // apply clear or add, start test setup
      logic edge_step; // evaluate one edge and advance
      logic finish;    // build the result
   } cmd_type;

   typedef struct packed {
      logic is_test;
      logic edges_done;
   } status_type;
endpackage
`default_nettype wire

// ===== rtl/pef_datapath.sv =====
// Datapath: vertex memory, bounding box, edge test unit and result register.
// Depends on pef_pkg; driven by pef_control through command and status.
`default_nettype none
module pef_datapath #(
   parameter int MAX_VERTICES = pef_pkg::MaxVerticesDefault,
   parameter int COORD_BITS   = pef_pkg::CoordBitsDefault,
   parameter int LABEL_BITS   = pef_pkg::LabelBitsDefault
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire pef_pkg::cmd_type      cmd,
   output pef_pkg::status_type        status,
   input  wire                        csr_write,
   input  wire [pef_pkg::CsrIndexBits-1:0] csr_index,
   input  wire [LABEL_BITS-1:0]       csr_data,
   input  wire [1:0]                  req_command,
   input  wire signed [COORD_BITS-1:0] req_coord_x,
   input  wire signed [COORD_BITS-1:0] req_coord_y,
   input  wire [LABEL_BITS-1:0]       req_mask_word,
   input  wire [LABEL_BITS-1:0]       req_label_word,
   output logic                       rsp_inside_res,
   output logic [LABEL_BITS-1:0]      rsp_label_out,
   output logic [pef_pkg::DimBits-1:0] rsp_box_x_lo,
   output logic [pef_pkg::DimBits-1:0] rsp_box_y_lo,
   output logic [pef_pkg::DimBits-1:0] rsp_box_x_hi,
   output logic [pef_pkg::DimBits-1:0] rsp_box_y_hi,
   output logic [$clog2(MAX_VERTICES+1)-1:0] rsp_vertex_count,
   output logic                       rsp_overflow
);
   localparam int AW = $clog2(MAX_VERTICES);
   localparam int CW = $clog2(MAX_VERTICES+1);
   localparam int DB = pef_pkg::DimBits;
   localparam int BW = (COORD_BITS > DB ? COORD_BITS : DB) + 2;
   localparam int PW = 2*(COORD_BITS+1) + 1;

   logic [pef_pkg::DimBits-1:0] width_ff, height_ff;
   logic [LABEL_BITS-1:0] fill_ff, maskl_ff;
   logic mask_en_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= DB'(4096);
         height_ff  <= DB'(4096);
         fill_ff    <= LABEL_BITS'(1);
         maskl_ff   <= '0;
         mask_en_ff <= 1'b0;
      end else if (csr_write) begin
         unique case (csr_index)
            pef_pkg::CSR_IMAGE_WIDTH:  width_ff   <= csr_data[DB-1:0];
            pef_pkg::CSR_IMAGE_HEIGHT: height_ff  <= csr_data[DB-1:0];
            pef_pkg::CSR_FILL_LABEL:   fill_ff    <= csr_data;
            pef_pkg::CSR_MASK_LABEL:   maskl_ff   <= csr_data;
            pef_pkg::CSR_MASK_ENABLE:  mask_en_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   logic [1:0] op_ff;
   logic signed [COORD_BITS-1:0] px_ff, py_ff;
   logic [LABEL_BITS-1:0] mword_ff, lword_ff;
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         op_ff    <= req_command;
         px_ff    <= req_coord_x;
         py_ff    <= req_coord_y;
         mword_ff <= req_mask_word;
         lword_ff <= req_label_word;
      end
   end

   logic signed [COORD_BITS-1:0] xmem [MAX_VERTICES];
   logic signed [COORD_BITS-1:0] ymem [MAX_VERTICES];
   logic [CW-1:0] count_ff;
   logic signed [BW-1:0] min_x_ff, min_y_ff, max_x_ff, max_y_ff;
   logic ovf_ff;
   logic signed [BW-1:0] cxw, cyw;
   assign cxw = BW'(px_ff);
   assign cyw = BW'(py_ff);

   always_ff @(posedge clock) begin
      if (cmd.exec && op_ff == pef_pkg::CMD_ADD && count_ff < CW'(MAX_VERTICES)) begin
         xmem[count_ff[AW-1:0]] <= px_ff;
         ymem[count_ff[AW-1:0]] <= py_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         min_x_ff <= BW'(4096);
         min_y_ff <= BW'(4096);
         max_x_ff <= '0;
         max_y_ff <= '0;
         ovf_ff   <= 1'b0;
      end else if (cmd.exec) begin
         ovf_ff <= 1'b0;
         if (op_ff == pef_pkg::CMD_CLEAR) begin
            count_ff <= '0;
            min_x_ff <= BW'({1'b0, width_ff});
            min_y_ff <= BW'({1'b0, height_ff});
            max_x_ff <= '0;
            max_y_ff <= '0;
         end else if (op_ff == pef_pkg::CMD_ADD) begin
            if (count_ff >= CW'(MAX_VERTICES)) begin
               ovf_ff <= 1'b1;
            end else begin
               count_ff <= count_ff + CW'(1);
               if (cxw < min_x_ff) min_x_ff <= cxw;
               if (cxw > max_x_ff) max_x_ff <= cxw;
               if (cyw < min_y_ff) min_y_ff <= cyw;
               if (cyw > max_y_ff) max_y_ff <= cyw;
            end
         end
      end
   end

   // Edge walk: registered reads of corner i and corner i+1 (wrapping).
   logic [CW-1:0] idx_ff;
   logic signed [COORD_BITS-1:0] ax_ff, ay_ff, bx_ff, by_ff, fx_ff, fy_ff;
   logic first_ff, odd_ff, hit_ff, edge_vld_ff;
   logic [CW-1:0] nidx;
   assign nidx = idx_ff + CW'(1);

   logic signed [COORD_BITS:0] dxa, dya, dxb, dyb;
   logic signed [PW-1:0] lhs, rhs, cr1, cr2;
   logic onb, crosses;
   always_comb begin
      dxa = (COORD_BITS+1)'(bx_ff) - (COORD_BITS+1)'(ax_ff);
      dya = (COORD_BITS+1)'(by_ff) - (COORD_BITS+1)'(ay_ff);
      dxb = (COORD_BITS+1)'(px_ff) - (COORD_BITS+1)'(ax_ff);
      dyb = (COORD_BITS+1)'(py_ff) - (COORD_BITS+1)'(ay_ff);
      cr1 = PW'(dxa) * PW'(dyb);
      cr2 = PW'(dya) * PW'(dxb);
      onb = (px_ff >= (ax_ff < bx_ff ? ax_ff : bx_ff)) &&
            (px_ff <= (ax_ff < bx_ff ? bx_ff : ax_ff)) &&
            (py_ff >= (ay_ff < by_ff ? ay_ff : by_ff)) &&
            (py_ff <= (ay_ff < by_ff ? by_ff : ay_ff)) && (cr1 == cr2);
      lhs = PW'(dxb) * PW'(dya);
      rhs = PW'(dyb) * PW'(dxa);
      crosses = ((ay_ff > py_ff) != (by_ff > py_ff)) &&
                ((dya > 0) ? (lhs < rhs) : (lhs > rhs));
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         idx_ff <= '0;
         odd_ff <= 1'b0;
         hit_ff <= 1'b0;
         edge_vld_ff <= 1'b0;
         fx_ff <= xmem[0];
         fy_ff <= ymem[0];
         bx_ff <= xmem[0];
         by_ff <= ymem[0];
         first_ff <= 1'b1;
      end else if (cmd.edge_step) begin
         if (edge_vld_ff) begin
            if (onb) hit_ff <= 1'b1;
            if (crosses) odd_ff <= ~odd_ff;
         end
         // Load the next edge from the previous end point.
         ax_ff <= bx_ff;
         ay_ff <= by_ff;
         if (nidx >= count_ff) begin
            bx_ff <= fx_ff;
            by_ff <= fy_ff;
         end else begin
            bx_ff <= xmem[nidx[AW-1:0]];
            by_ff <= ymem[nidx[AW-1:0]];
         end
         edge_vld_ff <= (idx_ff < count_ff);
         idx_ff <= nidx;
         first_ff <= 1'b0;
      end
   end

   // Clip to the image.
   logic signed [BW-1:0] wx, hy, xlo, ylo, xhi, yhi, t;
   always_comb begin
      wx  = BW'({1'b0, width_ff});
      hy  = BW'({1'b0, height_ff});
      t   = (min_x_ff < wx) ? min_x_ff : wx;
      xlo = (t < 0) ? '0 : t;
      t   = (min_y_ff < hy) ? min_y_ff : hy;
      ylo = (t < 0) ? '0 : t;
      t   = ((max_x_ff < 0) ? '0 : max_x_ff) + BW'(1);
      xhi = (t > wx) ? wx : t;
      t   = ((max_y_ff < 0) ? '0 : max_y_ff) + BW'(1);
      yhi = (t > hy) ? hy : t;
   end

   logic in_box, masked, filled;
   assign in_box = cxw >= xlo && cxw < xhi && cyw >= ylo && cyw < yhi;
   assign masked = mask_en_ff && ((mword_ff & maskl_ff) != '0);
   assign filled = (op_ff == pef_pkg::CMD_TEST) && in_box && (count_ff != '0) &&
                   !masked && (hit_ff || odd_ff);

   assign status.is_test    = (op_ff == pef_pkg::CMD_TEST);
   // Pipeline holds one edge in flight; done after count edges evaluated.
   assign status.edges_done = !first_ff && !edge_vld_ff && (idx_ff > count_ff);

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_inside_res   <= filled;
         rsp_label_out    <= (op_ff == pef_pkg::CMD_TEST) ?
                             (filled ? (lword_ff | fill_ff) : lword_ff) : '0;
         rsp_box_x_lo     <= xlo[DB-1:0];
         rsp_box_y_lo     <= ylo[DB-1:0];
         rsp_box_x_hi     <= xhi[DB-1:0];
         rsp_box_y_hi     <= yhi[DB-1:0];
         rsp_vertex_count <= count_ff;
         rsp_overflow     <= ovf_ff;
      end
   end
endmodule
`default_nettype wire

// ===== rtl/pef_control.sv =====
// Controller: sequences latch, execute, edge walk and result handshake.
// Depends on pef_pkg; commands pef_datapath.
`default_nettype none
module pef_control (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  wire                   rsp_stall,
   input  wire pef_pkg::status_type status,
   output pef_pkg::cmd_type      cmd
);
   typedef enum logic [2:0] {S_IDLE, S_EXEC, S_WALK, S_DONE, S_OUT} state_type;
   state_type state_ff;
   logic rsp_valid_ff;
   logic out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd = '0;
      cmd.latch     = (state_ff == S_IDLE) && req_valid;
      cmd.exec      = (state_ff == S_EXEC);
      cmd.edge_step = (state_ff == S_WALK);
      cmd.finish    = (state_ff == S_DONE) && out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: if (req_valid) state_ff <= S_EXEC;
            S_EXEC: state_ff <= status.is_test ? S_WALK : S_DONE;
            S_WALK: if (status.edges_done) state_ff <= S_DONE;
            S_DONE: if (out_free) begin
               rsp_valid_ff <= 1'b1;
               state_ff     <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

// ===== rtl/polygon_even_odd_fill.sv =====
// Top level of the even-odd polygon fill block.
// Depends on pef_pkg; instantiates pef_control and pef_datapath.
`default_nettype none
// Each word is one command (clear, add vertex, test pixel or unused code 3),
// and each produces exactly one result word. Clear and add are latched, then
// applied in the execute state, and the done state builds their result. A
// pixel test walks the stored edges one per cycle through the edge test unit
// before the done state. One word is processed at a time; a finished result
// waits in the output register while the next word is taken.
module polygon_even_odd_fill #(
   parameter int MAX_VERTICES = pef_pkg::MaxVerticesDefault,
   parameter int COORD_BITS   = pef_pkg::CoordBitsDefault,
   parameter int LABEL_BITS   = pef_pkg::LabelBitsDefault
) (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         csr_write,
   input  wire [pef_pkg::CsrIndexBits-1:0] csr_index,
   input  wire [LABEL_BITS-1:0]        csr_data,
   input  wire                         req_valid,
   output logic                        req_stall,
   input  wire [1:0]                   req_command,
   input  wire signed [COORD_BITS-1:0] req_coord_x,
   input  wire signed [COORD_BITS-1:0] req_coord_y,
   input  wire [LABEL_BITS-1:0]        req_mask_word,
   input  wire [LABEL_BITS-1:0]        req_label_word,
   output logic                        rsp_valid,
   input  wire                         rsp_stall,
   output logic                        rsp_inside_res,
   output logic [LABEL_BITS-1:0]       rsp_label_out,
   output logic [pef_pkg::DimBits-1:0] rsp_box_x_lo,
   output logic [pef_pkg::DimBits-1:0] rsp_box_y_lo,
   output logic [pef_pkg::DimBits-1:0] rsp_box_x_hi,
   output logic [pef_pkg::DimBits-1:0] rsp_box_y_hi,
   output logic [$clog2(MAX_VERTICES+1)-1:0] rsp_vertex_count,
   output logic                        rsp_overflow
);
   pef_pkg::cmd_type    cmd;
   pef_pkg::status_type status;

   pef_control u_control (
      .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall,
      .status, .cmd
   );

   pef_datapath #(
      .MAX_VERTICES(MAX_VERTICES), .COORD_BITS(COORD_BITS), .LABEL_BITS(LABEL_BITS)
   ) u_datapath (
      .clock, .reset, .cmd, .status, .csr_write, .csr_index, .csr_data,
      .req_command, .req_coord_x, .req_coord_y, .req_mask_word, .req_label_word,
      .rsp_inside_res, .rsp_label_out, .rsp_box_x_lo, .rsp_box_y_lo,
      .rsp_box_x_hi, .rsp_box_y_hi, .rsp_vertex_count, .rsp_overflow
   );
endmodule
`default_nettype wire

// ===== test/tb_top.sv =====
// Self-checking testbench for the even-odd polygon fill block.
// Depends on pef_pkg and polygon_even_odd_fill; it holds its own predictor.
`timescale 1ns / 1ps

typedef struct {
   logic        hit;
   logic [31:0] label;
   logic [12:0] x_lo, y_lo, x_hi, y_hi;
   logic [6:0]  count;
   logic        ovf;
} fill_result_type;

class fill_scoreboard_type;
   int          img_w = 4096, img_h = 4096;
   logic [31:0] fill_lbl = 1, mask_lbl = 0;
   logic        mask_on = 0;
   int          cx_tab[64], cy_tab[64];
   int          n_corner = 0;
   int          min_x = 4096, min_y = 4096, max_x = 0, max_y = 0;
   fill_result_type expected_q[$];
   int          errors = 0;

   function void set_reg(logic [2:0] idx, logic [31:0] d);
      case (idx)
         pef_pkg::CSR_IMAGE_WIDTH: img_w = d[12:0];
         pef_pkg::CSR_IMAGE_HEIGHT: img_h = d[12:0];
         pef_pkg::CSR_FILL_LABEL: fill_lbl = d;
         pef_pkg::CSR_MASK_LABEL: mask_lbl = d;
         pef_pkg::CSR_MASK_ENABLE: mask_on = d[0];
         default: ;
      endcase
   endfunction

   function bit on_segment(longint ax, ay, bx, by, px, py);
      if (px < (ax < bx ? ax : bx) || px > (ax < bx ? bx : ax)) return 0;
      if (py < (ay < by ? ay : by) || py > (ay < by ? by : ay)) return 0;
      return (bx - ax) * (py - ay) - (by - ay) * (px - ax) == 0;
   endfunction

   function bit ray_hit(longint ax, ay, bx, by, px, py);
      longint dy, lhs, rhs;
      if ((ay > py) == (by > py)) return 0;
      dy = by - ay;
      lhs = (px - ax) * dy;
      rhs = (py - ay) * (bx - ax);
      return dy > 0 ? (lhs < rhs) : (lhs > rhs);
   endfunction

   function bit in_polygon(int px, int py);
      bit odd = 0;
      int j;
      for (int i = 0; i < n_corner; i++) begin
         j = (i + 1 < n_corner) ? i + 1 : 0;
         if (on_segment(cx_tab[i], cy_tab[i], cx_tab[j], cy_tab[j], px, py)) return 1;
         if (ray_hit(cx_tab[i], cy_tab[i], cx_tab[j], cy_tab[j], px, py)) odd = !odd;
      end
      return odd;
   endfunction

   function void note_word(logic [1:0] cmd, int cx, int cy, logic [31:0] mw, lw);
      fill_result_type r;
      int xlo, ylo, xhi, yhi;
      bit in_box;
      r.hit = 0;
      r.label = 0;
      r.ovf = 0;
      if (cmd == pef_pkg::CMD_CLEAR) begin
         n_corner = 0;
         min_x = img_w;
         min_y = img_h;
         max_x = 0;
         max_y = 0;
      end else if (cmd == pef_pkg::CMD_ADD) begin
         if (n_corner >= 64) begin
            r.ovf = 1;
         end else begin
            cx_tab[n_corner] = cx;
            cy_tab[n_corner] = cy;
            n_corner++;
            if (cx < min_x) min_x = cx;
            if (cx > max_x) max_x = cx;
            if (cy < min_y) min_y = cy;
            if (cy > max_y) max_y = cy;
         end
      end
      xlo = min_x < img_w ? min_x : img_w;
      if (xlo < 0) xlo = 0;
      ylo = min_y < img_h ? min_y : img_h;
      if (ylo < 0) ylo = 0;
      xhi = (max_x < 0 ? 0 : max_x) + 1;
      if (xhi > img_w) xhi = img_w;
      yhi = (max_y < 0 ? 0 : max_y) + 1;
      if (yhi > img_h) yhi = img_h;
      if (cmd == pef_pkg::CMD_TEST) begin
         in_box = cx >= xlo && cx < xhi && cy >= ylo && cy < yhi;
         r.label = lw;
         if (in_box && n_corner > 0 && !(mask_on && (mw & mask_lbl) != 0)
             && in_polygon(cx, cy)) begin
            r.hit = 1;
            r.label = lw | fill_lbl;
         end
      end
      r.x_lo = xlo[12:0];
      r.y_lo = ylo[12:0];
      r.x_hi = xhi[12:0];
      r.y_hi = yhi[12:0];
      r.count = n_corner[6:0];
      expected_q.insert(expected_q.size(), r);
   endfunction

   function void report(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      if (errors <= 50) $display("mismatch on %s: got %0h, expected %0h", what, got, want);
   endfunction

   function void check_result(fill_result_type g);
      fill_result_type e;
      if (expected_q.size() == 0) begin
         report("unexpected result word", 1, 0);
         return;
      end
      e = expected_q.pop_front();
      if (g.hit !== e.hit) report("inside_res", g.hit, e.hit);
      if (g.label !== e.label) report("label_out", g.label, e.label);
      if (g.x_lo !== e.x_lo) report("box_x_lo", g.x_lo, e.x_lo);
      if (g.y_lo !== e.y_lo) report("box_y_lo", g.y_lo, e.y_lo);
      if (g.x_hi !== e.x_hi) report("box_x_hi", g.x_hi, e.x_hi);
      if (g.y_hi !== e.y_hi) report("box_y_hi", g.y_hi, e.y_hi);
      if (g.count !== e.count) report("vertex_count", g.count, e.count);
      if (g.ovf !== e.ovf) report("overflow", g.ovf, e.ovf);
   endfunction
endclass

module tb_top;
   logic clock = 0, reset = 1;
   logic csr_write = 0;
   logic [2:0] csr_index = '0;
   logic [31:0] csr_data = '0;
   logic req_valid = 0;
   logic req_stall;
   logic [1:0] req_command = pef_pkg::CMD_CLEAR;
   logic signed [12:0] req_coord_x = '0, req_coord_y = '0;
   logic [31:0] req_mask_word = '0, req_label_word = '0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic rsp_inside_res, rsp_overflow;
   logic [31:0] rsp_label_out;
   logic [12:0] rsp_box_x_lo, rsp_box_y_lo, rsp_box_x_hi, rsp_box_y_hi;
   logic [6:0] rsp_vertex_count;

   fill_scoreboard_type sb = new();
   bit calm = 0;
   bit hold_ask = 0;
   int cycles = 0;
   int vx[$], vy[$];

   polygon_even_odd_fill dut (.*);

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > 1000000) begin
         $display("polygon_even_odd_fill test failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      fill_result_type g;
      if (!reset && rsp_valid && !rsp_stall) begin
         g.hit = rsp_inside_res;
         g.label = rsp_label_out;
         g.x_lo = rsp_box_x_lo;
         g.y_lo = rsp_box_y_lo;
         g.x_hi = rsp_box_x_hi;
         g.y_hi = rsp_box_y_hi;
         g.count = rsp_vertex_count;
         g.ovf = rsp_overflow;
         sb.check_result(g);
      end
   end

   initial begin
      forever begin
         @(posedge clock);
         if (hold_ask) begin
            hold_ask = 0;
            rsp_stall <= 1;
            repeat (400) @(posedge clock);
         end else begin
            rsp_stall <= !calm && $urandom_range(99) < 34;
         end
      end
   end

   task automatic write_reg(logic [2:0] idx, logic [31:0] d);
      csr_write <= 1;
      csr_index <= idx;
      csr_data <= d;
      @(posedge clock);
      csr_write <= 0;
      sb.set_reg(idx, d);
      @(posedge clock);
   endtask

   task automatic send_word(logic [1:0] cmd, int x, int y, logic [31:0] mw, logic [31:0] lw);
      if (!calm && $urandom_range(99) < 34) begin
         req_valid <= 0;
         do @(posedge clock); while ($urandom_range(99) < 34);
      end
      req_valid <= 1;
      req_command <= cmd;
      req_coord_x <= 13'(x);
      req_coord_y <= 13'(y);
      req_mask_word <= mw;
      req_label_word <= lw;
      do @(posedge clock); while (req_stall !== 1'b0);
      sb.note_word(cmd, $signed(13'(x)), $signed(13'(y)), mw, lw);
      if (cmd == pef_pkg::CMD_CLEAR) begin
         vx.delete();
         vy.delete();
      end else if (cmd == pef_pkg::CMD_ADD) begin
         vx.insert(vx.size(), $signed(13'(x)));
         vy.insert(vy.size(), $signed(13'(y)));
      end
   endtask

   task automatic drain();
      req_valid <= 0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   function automatic int near(int lo, int hi);
      int v = lo + int'($urandom_range(hi - lo));
      return v < -4096 ? -4096 : (v > 4095 ? 4095 : v);
   endfunction

   task automatic test_pixel(int x, int y);
      logic [31:0] mw = $urandom_range(3) == 0 ? 32'h0 : $urandom;
      send_word(pef_pkg::CMD_TEST, x, y, mw, $urandom);
   endtask

   task automatic polygon_round();
      int n, k, span;
      span = $urandom_range(3) == 0 ? 4096 : 60;
      send_word(pef_pkg::CMD_CLEAR, $urandom, $urandom, $urandom, $urandom);
      if ($urandom_range(3) == 0) test_pixel(near(-2, 10), near(-2, 10));
      n = $urandom_range(19) == 0 ? 66 : $urandom_range(3, 8);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(29) == 0)
            send_word(pef_pkg::CMD_ADD, $urandom, $urandom, $urandom, $urandom);
         else if (i > 0 && $urandom_range(9) == 0)
            send_word(pef_pkg::CMD_ADD, vx[i - 1], vy[i - 1], $urandom, $urandom);
         else
            send_word(pef_pkg::CMD_ADD, near(-span / 8, span), near(-span / 8, span),
                      $urandom, $urandom);
      end
      for (int t = 0; t < 10; t++) begin
         k = $urandom_range(vx.size() - 1);
         case ($urandom_range(5))
            0: test_pixel(vx[k], vy[k]);
            1: test_pixel((vx[k] + vx[(k + 1) % vx.size()]) / 2,
                          (vy[k] + vy[(k + 1) % vy.size()]) / 2);
            2: send_word(pef_pkg::CMD_UNUSED, $urandom, $urandom, $urandom, $urandom);
            default: test_pixel(near(sb.min_x - 2, sb.max_x + 2),
                                near(sb.min_y - 2, sb.max_y + 2));
         endcase
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed words at reset settings.
      test_pixel(0, 0);
      send_word(pef_pkg::CMD_UNUSED, -1, -1, 32'hffffffff, 32'hffffffff);
      send_word(pef_pkg::CMD_CLEAR, 0, 0, 0, 0);
      send_word(pef_pkg::CMD_ADD, 0, 0, 0, 0);
      send_word(pef_pkg::CMD_ADD, 10, 0, 0, 0);
      send_word(pef_pkg::CMD_ADD, 10, 10, 0, 0);
      send_word(pef_pkg::CMD_ADD, 0, 10, 0, 0);
      send_word(pef_pkg::CMD_TEST, 5, 5, 32'hffffffff, 32'h0);
      send_word(pef_pkg::CMD_TEST, 10, 5, 0, 32'h80000000);
      send_word(pef_pkg::CMD_TEST, 0, 0, 0, 32'hffffffff);
      send_word(pef_pkg::CMD_TEST, 5, 10, 0, 0);
      send_word(pef_pkg::CMD_TEST, 11, 5, 0, 32'h1234);
      send_word(pef_pkg::CMD_TEST, -1, 5, 0, 0);
      send_word(pef_pkg::CMD_ADD, -4096, -4096, 0, 0);
      send_word(pef_pkg::CMD_ADD, 4095, 4095, 0, 0);
      send_word(pef_pkg::CMD_ADD, 4095, 4095, 0, 0);
      send_word(pef_pkg::CMD_TEST, 4095, 4095, 0, 0);
      send_word(pef_pkg::CMD_TEST, 2000, 2000, 0, 0);
      send_word(pef_pkg::CMD_TEST, -4096, 0, 0, 0);
      send_word(pef_pkg::CMD_TEST, 0, 4095, 0, 0);
      drain();

      for (int p = 0; p < 12; p++) begin
         write_reg(pef_pkg::CSR_IMAGE_WIDTH,
                   32'(p == 1 ? 1 : (p == 2 ? 4096 : $urandom_range(20, 80))));
         write_reg(pef_pkg::CSR_IMAGE_HEIGHT,
                   32'(p == 1 ? 1 : (p == 3 ? 4096 : $urandom_range(20, 80))));
         write_reg(pef_pkg::CSR_FILL_LABEL,
                   p == 4 ? 32'h0 : (p == 5 ? 32'hffffffff : $urandom));
         write_reg(pef_pkg::CSR_MASK_LABEL, p == 6 ? 32'hffffffff : $urandom);
         write_reg(pef_pkg::CSR_MASK_ENABLE, 32'(p % 2));
         calm = (p == 7);
         if (p == 8) hold_ask = 1;
         // Leftover polygon is tested against the new clip first.
         test_pixel(near(-2, 30), near(-2, 30));
         for (int r = 0; r < 3; r++) begin
            polygon_round();
            if (p == 9 && r == 1) begin
               req_valid <= 0;
               while (sb.expected_q.size() != 0) @(posedge clock);
            end
         end
         calm = 0;
         drain();
      end

      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (sb.expected_q.size() != 0) sb.report("results missing", sb.expected_q.size(), 0);
      if (sb.errors == 0)
         $display("polygon_even_odd_fill test passed");
      else
         $display("polygon_even_odd_fill test failed");
      $finish;
   end
endmodule
